### src/acpu_pkg.sv
// Package for the accumulator CPU execute unit: request/result structs,
// controller states, datapath command struct and opcode helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package acpu_pkg;

	localparam int ADDR_BITS_DEF = 16;

	localparam logic [1:0] FUNC_EXEC  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [7:0] OP_NOP  = 8'h18;
	localparam logic [7:0] OP_HALT = 8'h19;

	// math function codes
	localparam logic [2:0] F_AND = 3'd0;
	localparam logic [2:0] F_OR  = 3'd1;
	localparam logic [2:0] F_XOR = 3'd2;
	localparam logic [2:0] F_ADD = 3'd3;
	localparam logic [2:0] F_SUB = 3'd4;
	localparam logic [2:0] F_INC = 3'd5;
	localparam logic [2:0] F_DEC = 3'd6;
	localparam logic [2:0] F_NOT = 3'd7;

	// destination / source / method codes
	localparam logic [1:0] LOC_PTR   = 2'd0;
	localparam logic [1:0] LOC_ACC   = 2'd1;
	localparam logic [1:0] LOC_MAR   = 2'd2;
	localparam logic [1:0] LOC_OPND  = 2'd3;
	localparam logic [1:0] METH_ADDR  = 2'd0;
	localparam logic [1:0] METH_CONST = 2'd1;
	localparam logic [1:0] METH_PTR   = 2'd2;
	localparam logic [1:0] METH_NONE  = 2'd3;

	// branch condition codes
	localparam logic [2:0] BR_ALWAYS   = 3'd0;
	localparam logic [2:0] BR_ZERO     = 3'd1;
	localparam logic [2:0] BR_NZERO    = 3'd2;
	localparam logic [2:0] BR_NEG      = 3'd3;
	localparam logic [2:0] BR_NEG_ZERO = 3'd4;
	localparam logic [2:0] BR_POS      = 3'd5;
	localparam logic [2:0] BR_NNEG     = 3'd6;
	localparam logic [2:0] BR_NEVER    = 3'd7;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  opcode;
		logic [15:0] instr_addr;
		logic [15:0] fallthrough_pc;
		logic [15:0] mem_addr;
		logic [7:0]  mem_data;
	} req_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [7:0]  acc_value;
		logic [15:0] mar_value;
		logic [7:0]  read_byte;
		logic        halted;
		logic        bad_opcode;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_OPA_HI, ST_OPA_LO, ST_D, ST_S_HI, ST_S_LO,
		ST_EXEC, ST_WR_HI, ST_WR_LO, ST_DONE
	} state_t;

	// address selects for the memory port
	typedef enum logic [2:0] {
		AS_IA1, AS_IA2, AS_MAR, AS_MAR1, AS_OPA, AS_OPA1, AS_CST, AS_CST1
	} asel_t;

	// fetched-byte targets
	typedef enum logic [2:0] {
		LD_NONE, LD_OPA_HI, LD_OPA_LO, LD_D, LD_S_HI, LD_S_LO
	} ldsel_t;

	typedef struct packed {
		logic   latch_req;
		logic   mem_rd;
		logic   mem_wr;
		asel_t  asel;
		logic   wr_hi;   // write high byte of write value, else low
		ldsel_t ld;      // byte arriving this cycle (from read issued last cycle)
		logic   exec;    // compute result, update registers
		logic   take_br; // load the branch target into next_pc
		logic   done;
	} cmd_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic       acc_zero;
		logic       acc_neg;
	} sts_t;

	function automatic logic is_math(input logic [7:0] op);
		return op[7];
	endfunction
	function automatic logic is_mem(input logic [7:0] op);
		return op[7:4] == 4'h0;
	endfunction
	function automatic logic is_br(input logic [7:0] op);
		return op[7:3] == 5'b00010;
	endfunction

endpackage
`default_nettype wire

### src/acpu_ram.sv
// Generic single-port RAM, one write or read a cycle, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module acpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### src/acpu_ctrl.sv
// Controller state machine: sequences memory reads, execute and writes.
// Depends on acpu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acpu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire acpu_pkg::req_t req,
	input  wire acpu_pkg::sts_t sts,
	output logic               busy,
	output acpu_pkg::cmd_t     cmd
);
	acpu_pkg::state_t state_q, state_d;
	logic [7:0] op;
	logic [1:0] dsel, ssel, meth;
	logic       wide, load, use_mar, take;

	assign op      = sts.opcode;
	assign dsel    = op[3:2];
	assign ssel    = op[1:0];
	assign meth    = op[1:0];
	assign wide    = dsel == acpu_pkg::LOC_MAR;
	assign load    = op[3];
	assign use_mar = op[2];

	always_comb begin
		case (op[2:0])
			acpu_pkg::BR_ALWAYS:   take = 1'b1;
			acpu_pkg::BR_ZERO:     take = sts.acc_zero;
			acpu_pkg::BR_NZERO:    take = !sts.acc_zero;
			acpu_pkg::BR_NEG:      take = sts.acc_neg;
			acpu_pkg::BR_NEG_ZERO: take = sts.acc_neg || sts.acc_zero;
			acpu_pkg::BR_POS:      take = !sts.acc_neg && !sts.acc_zero;
			acpu_pkg::BR_NNEG:     take = !sts.acc_neg;
			default: take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acpu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Reads are issued in one state; the byte is latched by the next one.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.asel = acpu_pkg::AS_IA1;
		cmd.ld = acpu_pkg::LD_NONE;
		busy = state_q != acpu_pkg::ST_IDLE;
		case (state_q)
			acpu_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch_req = 1'b1;
					case (req.func)
						acpu_pkg::FUNC_EXEC: begin
							// operand address high byte, always read
							cmd.mem_rd = 1'b1;
							cmd.asel = acpu_pkg::AS_IA1;
							state_d = acpu_pkg::ST_OPA_HI;
						end
						acpu_pkg::FUNC_READ: begin
							cmd.mem_rd = 1'b1;
							state_d = acpu_pkg::ST_DONE;
						end
						default: state_d = acpu_pkg::ST_DONE;
					endcase
				end
			end
			acpu_pkg::ST_OPA_HI: begin
				cmd.ld = acpu_pkg::LD_OPA_HI;
				cmd.mem_rd = 1'b1;
				cmd.asel = acpu_pkg::AS_IA2;
				state_d = acpu_pkg::ST_OPA_LO;
			end
			acpu_pkg::ST_OPA_LO: begin
				cmd.ld = acpu_pkg::LD_OPA_LO;
				// issue first data read: dest byte, or load byte
				state_d = acpu_pkg::ST_EXEC;
				if (acpu_pkg::is_math(op)) begin
					if (dsel == acpu_pkg::LOC_PTR || dsel == acpu_pkg::LOC_OPND) begin
						cmd.mem_rd = 1'b1;
						cmd.asel = (dsel == acpu_pkg::LOC_PTR) ? acpu_pkg::AS_MAR
							: acpu_pkg::AS_OPA;
						state_d = acpu_pkg::ST_D;
					end else begin
						state_d = acpu_pkg::ST_D;
					end
				end else if (acpu_pkg::is_mem(op) && load) begin
					if (meth == acpu_pkg::METH_ADDR || meth == acpu_pkg::METH_PTR
						|| (meth == acpu_pkg::METH_CONST && !use_mar)) begin
						cmd.mem_rd = 1'b1;
						cmd.asel = (meth == acpu_pkg::METH_ADDR) ? acpu_pkg::AS_OPA
							: (meth == acpu_pkg::METH_PTR) ? acpu_pkg::AS_MAR
							: acpu_pkg::AS_IA1;
						state_d = use_mar ? acpu_pkg::ST_S_HI : acpu_pkg::ST_S_LO;
					end
				end
			end
			acpu_pkg::ST_D: begin
				// dest byte (if read) arrives; issue source reads
				cmd.ld = (dsel == acpu_pkg::LOC_PTR || dsel == acpu_pkg::LOC_OPND)
					? acpu_pkg::LD_D : acpu_pkg::LD_NONE;
				state_d = acpu_pkg::ST_EXEC;
				if (ssel == acpu_pkg::LOC_PTR) begin
					cmd.mem_rd = 1'b1;
					cmd.asel = acpu_pkg::AS_MAR;
					state_d = acpu_pkg::ST_S_LO;
				end else if (ssel == acpu_pkg::LOC_MAR || ssel == acpu_pkg::LOC_OPND) begin
					cmd.mem_rd = 1'b1;
					cmd.asel = (ssel == acpu_pkg::LOC_OPND) ? acpu_pkg::AS_OPA
						: acpu_pkg::AS_CST;
					state_d = wide ? acpu_pkg::ST_S_HI : acpu_pkg::ST_S_LO;
				end
			end
			acpu_pkg::ST_S_HI: begin
				cmd.ld = acpu_pkg::LD_S_HI;
				cmd.mem_rd = 1'b1;
				if (acpu_pkg::is_math(op)) begin
					cmd.asel = (ssel == acpu_pkg::LOC_OPND) ? acpu_pkg::AS_OPA1
						: acpu_pkg::AS_CST1;
				end else begin
					cmd.asel = (meth == acpu_pkg::METH_ADDR) ? acpu_pkg::AS_OPA1
						: acpu_pkg::AS_MAR1;
				end
				state_d = acpu_pkg::ST_S_LO;
			end
			acpu_pkg::ST_S_LO: begin
				cmd.ld = acpu_pkg::LD_S_LO;
				state_d = acpu_pkg::ST_EXEC;
			end
			acpu_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.take_br = acpu_pkg::is_br(op) && take;
				state_d = acpu_pkg::ST_DONE;
				if (acpu_pkg::is_math(op)) begin
					if (dsel == acpu_pkg::LOC_PTR || dsel == acpu_pkg::LOC_OPND) begin
						state_d = acpu_pkg::ST_WR_LO;
					end
				end else if (acpu_pkg::is_mem(op) && !load
					&& (meth == acpu_pkg::METH_ADDR || meth == acpu_pkg::METH_PTR)) begin
					state_d = use_mar ? acpu_pkg::ST_WR_HI : acpu_pkg::ST_WR_LO;
				end
			end
			acpu_pkg::ST_WR_HI: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_hi = 1'b1;
				cmd.asel = (meth == acpu_pkg::METH_ADDR) ? acpu_pkg::AS_OPA
					: acpu_pkg::AS_MAR;
				state_d = acpu_pkg::ST_WR_LO;
			end
			acpu_pkg::ST_WR_LO: begin
				cmd.mem_wr = 1'b1;
				if (acpu_pkg::is_math(op)) begin
					cmd.asel = (dsel == acpu_pkg::LOC_PTR) ? acpu_pkg::AS_MAR
						: acpu_pkg::AS_OPA;
				end else if (use_mar) begin
					cmd.asel = (meth == acpu_pkg::METH_ADDR) ? acpu_pkg::AS_OPA1
						: acpu_pkg::AS_MAR1;
				end else begin
					cmd.asel = (meth == acpu_pkg::METH_ADDR) ? acpu_pkg::AS_OPA
						: acpu_pkg::AS_MAR;
				end
				state_d = acpu_pkg::ST_DONE;
			end
			acpu_pkg::ST_DONE: begin
				cmd.done = 1'b1;
				state_d = acpu_pkg::ST_IDLE;
			end
			default: state_d = acpu_pkg::ST_IDLE;
		endcase
	end

	ast_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> busy)
		else $error("write outside request");
	ast_done_next_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> state_q == acpu_pkg::ST_IDLE)
		else $error("done not followed by idle");
	ast_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not go busy");
endmodule
`default_nettype wire

### src/acpu_dp.sv
// Datapath: request latch, ACC/MAR, operand and data registers, ALU, memory.
// Depends on acpu_pkg and acpu_ram.
`timescale 1ns / 1ps
`default_nettype none
module acpu_dp #(
	parameter int ADDR_BITS = acpu_pkg::ADDR_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire acpu_pkg::req_t req,
	input  wire acpu_pkg::cmd_t cmd,
	output acpu_pkg::sts_t      sts,
	output logic                done,
	output acpu_pkg::res_t      res
);
	acpu_pkg::req_t req_q;
	logic [7:0]  acc_q;
	logic [15:0] mar_q, opa_q, s_q, next_q;
	logic [7:0]  d_q;
	logic        done_q;
	logic [15:0] addr16;
	logic [15:0] opa_now;
	logic [ADDR_BITS-1:0] ram_addr;
	logic [7:0]  ram_rd, ram_wd;
	logic [15:0] wr_val_q;
	logic [15:0] dv, sv, r;
	logic [1:0]  dsel, ssel, meth;
	logic        wide;
	logic [7:0]  op;

	assign op   = req_q.opcode;
	assign dsel = op[3:2];
	assign ssel = op[1:0];
	assign meth = op[1:0];
	assign wide = dsel == acpu_pkg::LOC_MAR;

	// low operand byte is still on the RAM output while it is being latched
	assign opa_now = (cmd.ld == acpu_pkg::LD_OPA_LO) ? {opa_q[15:8], ram_rd} : opa_q;

	always_comb begin
		case (cmd.asel)
			acpu_pkg::AS_IA1:  addr16 = req_q.instr_addr + 16'd1;
			acpu_pkg::AS_IA2:  addr16 = req_q.instr_addr + 16'd2;
			acpu_pkg::AS_MAR:  addr16 = mar_q;
			acpu_pkg::AS_MAR1: addr16 = mar_q + 16'd1;
			acpu_pkg::AS_OPA:  addr16 = opa_now;
			acpu_pkg::AS_OPA1: addr16 = opa_now + 16'd1;
			acpu_pkg::AS_CST:  addr16 = req_q.fallthrough_pc - (wide ? 16'd2 : 16'd1);
			acpu_pkg::AS_CST1: addr16 = req_q.fallthrough_pc - 16'd1;
			default:           addr16 = opa_now;
		endcase
		if (cmd.latch_req) begin
			addr16 = (req.func == acpu_pkg::FUNC_EXEC) ? req.instr_addr + 16'd1
				: req.mem_addr;
		end
	end

	assign ram_addr = addr16[ADDR_BITS-1:0];
	assign ram_wd = cmd.latch_req ? req.mem_data
		: (cmd.wr_hi ? wr_val_q[15:8] : wr_val_q[7:0]);

	acpu_ram #(.WIDTH(8), .DEPTH(2 ** ADDR_BITS)) u_ram (
		.clk   (clk),
		.we    (cmd.mem_wr || (cmd.latch_req && req.func == acpu_pkg::FUNC_WRITE)),
		.addr  (ram_addr),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	// operand values for the math op
	always_comb begin
		case (dsel)
			acpu_pkg::LOC_ACC: dv = {8'd0, acc_q};
			acpu_pkg::LOC_MAR: dv = mar_q;
			default:           dv = {8'd0, d_q};
		endcase
		// pointer source is a single byte even for MAR math
		case (ssel)
			acpu_pkg::LOC_ACC: sv = {8'd0, acc_q};
			acpu_pkg::LOC_PTR: sv = {8'd0, s_q[7:0]};
			default:           sv = wide ? s_q : {8'd0, s_q[7:0]};
		endcase
		case (op[6:4])
			acpu_pkg::F_AND: r = dv & sv;
			acpu_pkg::F_OR:  r = dv | sv;
			acpu_pkg::F_XOR: r = dv ^ sv;
			acpu_pkg::F_ADD: r = dv + sv;
			acpu_pkg::F_SUB: r = dv - sv;
			acpu_pkg::F_INC: r = dv + 16'd1;
			acpu_pkg::F_DEC: r = dv - 16'd1;
			default:         r = ~dv;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
		case (cmd.ld)
			acpu_pkg::LD_OPA_HI: opa_q[15:8] <= ram_rd;
			acpu_pkg::LD_OPA_LO: opa_q[7:0] <= ram_rd;
			acpu_pkg::LD_D:      d_q <= ram_rd;
			acpu_pkg::LD_S_HI:   s_q[15:8] <= ram_rd;
			acpu_pkg::LD_S_LO:   s_q[7:0] <= ram_rd;
			default: ;
		endcase
		if (cmd.exec) begin
			wr_val_q <= acpu_pkg::is_math(op) ? r
				: (op[2] ? mar_q : {acc_q, acc_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			mar_q  <= '0;
			done_q <= 1'b0;
			next_q <= '0;
		end else begin
			done_q <= cmd.done;
			if (cmd.latch_req) begin
				next_q <= (req.func == acpu_pkg::FUNC_EXEC) ? req.fallthrough_pc : 16'd0;
			end
			if (cmd.exec && req_q.func == acpu_pkg::FUNC_EXEC) begin
				if (acpu_pkg::is_math(op)) begin
					if (dsel == acpu_pkg::LOC_ACC) acc_q <= r[7:0];
					if (dsel == acpu_pkg::LOC_MAR) mar_q <= r;
				end else if (acpu_pkg::is_mem(op) && op[3]) begin
					if (!op[2]) begin
						if (meth != acpu_pkg::METH_NONE) acc_q <= s_q[7:0];
					end else if (meth == acpu_pkg::METH_CONST) begin
						mar_q <= opa_q;
					end else if (meth != acpu_pkg::METH_NONE) begin
						mar_q <= s_q;
					end
				end else if (cmd.take_br) begin
					next_q <= opa_q;
				end
			end
		end
	end

	// read byte arrives in the DONE cycle for a read request
	logic [7:0] rb_q;
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			rb_q <= (req_q.func == acpu_pkg::FUNC_READ) ? ram_rd : 8'd0;
		end
	end

	assign done = done_q;
	assign sts.opcode = req_q.opcode;
	assign sts.acc_zero = acc_q == 8'd0;
	assign sts.acc_neg = acc_q[7];

	always_comb begin
		res.next_pc   = next_q;
		res.acc_value = acc_q;
		res.mar_value = mar_q;
		res.read_byte = rb_q;
		res.halted    = req_q.func == acpu_pkg::FUNC_EXEC && op == acpu_pkg::OP_HALT;
		res.bad_opcode = req_q.func == acpu_pkg::FUNC_EXEC && !op[7] && op[6:4] != 3'd0
			&& !acpu_pkg::is_br(op) && op != acpu_pkg::OP_HALT && op != acpu_pkg::OP_NOP;
	end

	ast_exec_no_latch: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.latch_req))
		else $error("execute and request latch together");
	ast_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
	ast_mem_next_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && req_q.func != acpu_pkg::FUNC_EXEC) |-> next_q == 16'd0)
		else $error("memory access with nonzero next_pc");
endmodule
`default_nettype wire

### src/accumulator_cpu_execute_unit_top.sv
// Top level of the accumulator CPU execute unit: controller plus datapath.
// Depends on acpu_pkg, acpu_ctrl, acpu_dp, acpu_ram.
`timescale 1ns / 1ps
`default_nettype none
// Takes one request when start is high and busy low, then holds busy until
// the result shows for exactly one cycle with done high; the receiver cannot
// stall it. The time from the accepting edge to the edge that takes the result
// is set by the number of byte reads and writes the request needs on the
// single-port memory (for an instruction: operand address, destination, 8 or
// 16-bit source, up to two write-backs). busy drops while the result shows,
// so the next request can be taken at that same edge.
// Memory reads as undefined until written.
module accumulator_cpu_execute_unit_top #(
	parameter int ADDR_BITS = acpu_pkg::ADDR_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire acpu_pkg::req_t req,
	output logic                busy,
	output logic                done,
	output acpu_pkg::res_t      res
);
	acpu_pkg::cmd_t cmd;
	acpu_pkg::sts_t sts;

	acpu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	acpu_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.res    (res)
	);
endmodule
`default_nettype wire
